/* hw/rtl/lel_pkg.sv */
package lel_pkg;

    localparam int CoordW = 24;
    localparam int ScoreW = 16;
    localparam int CordW = 44;
    localparam int AngW = 28;
    localparam int SqW = 48;
    localparam int NumW = 31;
    localparam int DenW = 25;

    localparam logic signed [AngW-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [AngW-1:0] PI_Q24 = 28'sd52707179;
    localparam logic signed [CordW-1:0] CORDIC_K_Q30 = 44'sd652032874;

    localparam logic REG_NEAR_RANGE_OFFSET = 1'b0;
    localparam logic REG_FAKE_EXTREME_SCORE = 1'b1;

    typedef enum logic {
        CORDIC_VEC,
        CORDIC_ROT
    } cordic_mode_t;

    typedef enum logic [4:0] {
        S_IDLE,
        P_MX,
        P_MY,
        P_SUM,
        P_WAIT,
        S_DECIDE,
        S_GX,
        S_GY,
        S_GSUM,
        S_ROT,
        S_THR,
        S_CMP,
        S_DIV,
        S_DIVW,
        S_ASSIGN,
        S_OUT
    } state_t;

    function automatic logic [23:0] atan_q24(input logic [4:0] i);
        logic [23:0] v;
        unique case (i)
            5'd0: v = 24'd13176795;
            5'd1: v = 24'd7778716;
            5'd2: v = 24'd4110060;
            5'd3: v = 24'd2086331;
            5'd4: v = 24'd1047214;
            5'd5: v = 24'd524117;
            5'd6: v = 24'd262123;
            5'd7: v = 24'd131069;
            5'd8: v = 24'd65536;
            5'd9: v = 24'd32768;
            5'd10: v = 24'd16384;
            5'd11: v = 24'd8192;
            5'd12: v = 24'd4096;
            5'd13: v = 24'd2048;
            5'd14: v = 24'd1024;
            5'd15: v = 24'd512;
            5'd16: v = 24'd256;
            5'd17: v = 24'd128;
            5'd18: v = 24'd64;
            5'd19: v = 24'd32;
            5'd20: v = 24'd16;
            5'd21: v = 24'd8;
            5'd22: v = 24'd4;
            5'd23: v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/lel_cordic.sv */
module lel_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  lel_pkg::cordic_mode_t                 mode,
    input  logic signed [lel_pkg::CordW-1:0]      x_in,
    input  logic signed [lel_pkg::CordW-1:0]      y_in,
    input  logic signed [lel_pkg::AngW-1:0]       z_in,
    output logic                                  busy,
    output logic signed [lel_pkg::CordW-1:0]      y_out,
    output logic signed [lel_pkg::AngW-1:0]       z_out
);
    import lel_pkg::*;

    localparam int CW = $clog2(STEPS);

    cordic_mode_t               mode_reg;
    logic signed [CordW-1:0]    x_reg, x_next;
    logic signed [CordW-1:0]    y_reg, y_next;
    logic signed [AngW-1:0]     z_reg, z_next;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic signed [CordW-1:0]    xs, ys;
    logic signed [AngW-1:0]     at;
    logic                       pos;

    always_comb
    begin
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        at = $signed({4'b0, atan_q24(5'(cnt_reg))});
        pos = (mode_reg == CORDIC_VEC) ? !(y_reg > 0) : (z_reg >= 0);
        if (pos)
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= mode;
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign busy = busy_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

/* hw/rtl/lel_isqrt.sv */
module lel_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lel_pkg::SqW-1:0]     value,
    output logic                        busy,
    output logic [lel_pkg::CoordW-1:0]  root
);
    import lel_pkg::*;

    logic [SqW-1:0] bit_reg;
    logic [SqW-1:0] v_reg;
    logic [SqW-1:0] res_reg;
    logic [SqW:0]   sum;

    assign sum = {1'b0, res_reg} + {1'b0, bit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '0;
        end
        else if (start)
        begin
            bit_reg <= SqW'(1) << (SqW - 2);
        end
        else
        begin
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= value;
            res_reg <= '0;
        end
        else if (bit_reg != '0)
        begin
            if ({1'b0, v_reg} >= sum)
            begin
                v_reg <= v_reg - sum[SqW-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
    end

    assign busy = bit_reg != '0;
    assign root = res_reg[CoordW-1:0];

endmodule

/* hw/rtl/lel_div.sv */
module lel_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lel_pkg::NumW-1:0]    num,
    input  logic [lel_pkg::DenW-1:0]    den,
    output logic                        busy,
    output logic [lel_pkg::NumW-1:0]    quo
);
    import lel_pkg::*;

    localparam int CW = $clog2(NumW);

    logic [NumW-1:0] num_reg;
    logic [DenW-1:0] den_reg;
    logic [DenW-1:0] rem_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic [DenW:0]   t;
    logic            ge;

    assign t = {rem_reg, num_reg[NumW-1]};
    assign ge = t >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(NumW - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NumW-2:0], ge};
            rem_reg <= ge ? DenW'(t - {1'b0, den_reg}) : t[DenW-1:0];
        end
    end

    assign busy = busy_reg;
    assign quo = num_reg;

endmodule

/* hw/rtl/line_endpoint_likelihood.sv */
// Scores segment endpoints of a laser scan as extreme points. One segment is taken at a
// time. A segment that opens a frame, or follows no earlier segment, skips the gap test.
// A score whose denominator is not positive skips the divide. Each point's range comes
// from a bit-serial square root running beside a CORDIC bearing pass. The bearing gap
// needs one CORDIC rotation pass. Each score with a positive denominator needs a
// restoring divide. The next segment can be taken in the cycle after the result is
// loaded, and a stalled output delays that. A finished result may wait in the output
// register while the next segment is taken. The configuration registers may be written
// only while no segment is in flight.
module line_endpoint_likelihood #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [lel_pkg::CoordW-1:0] start_x,
    input  logic signed [lel_pkg::CoordW-1:0] start_y,
    input  logic signed [lel_pkg::CoordW-1:0] end_x,
    input  logic signed [lel_pkg::CoordW-1:0] end_y,
    input  logic                              first_segment,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lel_pkg::ScoreW-1:0]        start_score,
    output logic [lel_pkg::ScoreW-1:0]        prev_end_score,
    output logic                              prev_end_valid,
    output logic                              shared_vertex,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [16:0]                       cfg_data
);
    import lel_pkg::*;

    state_t state_reg, state_next;

    logic signed [CoordW-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic                     first_reg;
    logic                     phase_reg;
    logic signed [CoordW-1:0] last_x_reg, last_y_reg;
    logic signed [15:0]       last_b_reg;
    logic [CoordW-1:0]        last_r_reg;
    logic                     have_last_reg;
    logic [16:0]              near_off_reg;
    logic [ScoreW-1:0]        fake_reg;

    logic [49:0]              prod_reg;
    logic [49:0]              acc_reg;
    logic [CoordW-1:0]        pr_reg;
    logic signed [15:0]       pb_reg;
    logic [16:0]              sine_reg;
    logic [CoordW-1:0]        d_reg;
    logic                     shared_reg, exact_reg, prev_near_reg;
    logic [ScoreW-1:0]        score_reg;
    logic [ScoreW-1:0]        rs_reg, rp_reg;
    logic                     rv_reg, rsh_reg;

    logic                     out_valid_reg;
    logic [ScoreW-1:0]        o_s_reg, o_p_reg;
    logic                     o_v_reg, o_sh_reg;

    logic                     cd_start, sq_start, dv_start;
    logic                     cd_busy, sq_busy, dv_busy;
    cordic_mode_t             cd_mode;
    logic signed [CordW-1:0]  cd_x, cd_y, cd_yo;
    logic signed [AngW-1:0]   cd_z, cd_zo;
    logic [CoordW-1:0]        sq_root;
    logic [NumW-1:0]          dv_quo;

    logic signed [CoordW-1:0] px, py;
    logic signed [CordW-1:0]  vx0, vy0;
    logic signed [CordW-1:0]  vx, vy;
    logic signed [AngW-1:0]   vz;
    logic signed [16:0]       db;
    logic [16:0]              db_abs;
    logic signed [AngW-1:0]   h0, hf;
    logic signed [24:0]       mul_a, mul_b;
    logic signed [49:0]       mul_p;
    logic signed [CoordW:0]   dx, dy;
    logic signed [16:0]       bear_r;
    logic signed [CordW-1:0]  sin_raw;
    logic [16:0]              sin_c;
    logic signed [25:0]       den;
    logic                     linked;
    logic                     load_out;
    logic [49:0]              thr;

    assign linked = !first_reg && have_last_reg;
    assign px = phase_reg ? ex_reg : sx_reg;
    assign py = phase_reg ? ey_reg : sy_reg;
    assign dx = 25'(sx_reg) - 25'(last_x_reg);
    assign dy = 25'(sy_reg) - 25'(last_y_reg);

    always_comb
    begin
        vx0 = $signed({{4{px[CoordW-1]}}, px, 16'b0});
        vy0 = $signed({{4{py[CoordW-1]}}, py, 16'b0});
        if (px < 0)
        begin
            if (py >= 0)
            begin
                vx = vy0;
                vy = -vx0;
                vz = HALF_PI_Q24;
            end
            else
            begin
                vx = -vy0;
                vy = vx0;
                vz = -HALF_PI_Q24;
            end
        end
        else
        begin
            vx = vx0;
            vy = vy0;
            vz = '0;
        end
        db = 17'(pb_reg) - 17'(last_b_reg);
        db_abs = db[16] ? 17'(-db) : 17'(db);
        h0 = $signed({1'b0, db_abs, 10'b0});
        hf = (h0 > HALF_PI_Q24) ? PI_Q24 - h0 : h0;
        cd_mode = (state_reg == S_GSUM) ? CORDIC_ROT : CORDIC_VEC;
        cd_x = (cd_mode == CORDIC_ROT) ? CORDIC_K_Q30 : vx;
        cd_y = (cd_mode == CORDIC_ROT) ? '0 : vy;
        cd_z = (cd_mode == CORDIC_ROT) ? hf : vz;
    end

    always_comb
    begin
        unique case (state_reg)
            P_MX:
            begin
                mul_a = 25'(px);
                mul_b = 25'(px);
            end
            P_MY:
            begin
                mul_a = 25'(py);
                mul_b = 25'(py);
            end
            S_GX:
            begin
                mul_a = dx;
                mul_b = dx;
            end
            S_GY:
            begin
                mul_a = dy;
                mul_b = dy;
            end
            S_THR:
            begin
                mul_a = $signed({1'b0, pr_reg});
                mul_b = $signed({8'b0, sine_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign bear_r = 17'((cd_zo + 28'sd1024) >>> 11);
    assign sin_raw = cd_yo >>> 14;
    assign sin_c = (sin_raw < 0) ? 17'd0 :
                   (sin_raw > 44'sd65536) ? 17'd65536 : sin_raw[16:0];
    assign den = 26'sd65536 + $signed({2'b0, d_reg}) - $signed({9'b0, near_off_reg});
    assign thr = {prod_reg[47:0], 2'b0};
    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    lel_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .mode  (cd_mode),
        .x_in  (cd_x),
        .y_in  (cd_y),
        .z_in  (cd_z),
        .busy  (cd_busy),
        .y_out (cd_yo),
        .z_out (cd_zo)
    );

    lel_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (acc_reg[SqW-1:0] + prod_reg[SqW-1:0]),
        .busy  (sq_busy),
        .root  (sq_root)
    );

    lel_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (NumW'(1 << 30) + NumW'(den[DenW-1:1])),
        .den   (den[DenW-1:0]),
        .busy  (dv_busy),
        .quo   (dv_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready = 1'b0;
        cd_start = 1'b0;
        sq_start = 1'b0;
        dv_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = P_MX;
                end
            end
            P_MX:
            begin
                cd_start = 1'b1;
                state_next = P_MY;
            end
            P_MY:
            begin
                state_next = P_SUM;
            end
            P_SUM:
            begin
                sq_start = 1'b1;
                state_next = P_WAIT;
            end
            P_WAIT:
            begin
                if (!sq_busy && !cd_busy)
                begin
                    state_next = phase_reg ? S_OUT : S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = linked ? S_GX : S_DIV;
            end
            S_GX:
            begin
                state_next = S_GY;
            end
            S_GY:
            begin
                state_next = S_GSUM;
            end
            S_GSUM:
            begin
                cd_start = 1'b1;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (!cd_busy)
                begin
                    state_next = S_THR;
                end
            end
            S_THR:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (den > 0)
                begin
                    dv_start = 1'b1;
                    state_next = S_DIVW;
                end
                else
                begin
                    state_next = S_ASSIGN;
                end
            end
            S_DIVW:
            begin
                if (!dv_busy)
                begin
                    state_next = S_ASSIGN;
                end
            end
            S_ASSIGN:
            begin
                state_next = P_MX;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_off_reg <= 17'd6554;
            fake_reg <= 16'd8192;
            have_last_reg <= 1'b0;
            last_x_reg <= '0;
            last_y_reg <= '0;
            last_b_reg <= '0;
            last_r_reg <= '0;
            out_valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_NEAR_RANGE_OFFSET: near_off_reg <= cfg_data;
                    REG_FAKE_EXTREME_SCORE: fake_reg <= cfg_data[ScoreW-1:0];
                    default: ;
                endcase
            end
            if (state_reg == S_IDLE && in_valid)
            begin
                phase_reg <= 1'b0;
            end
            if (state_reg == S_ASSIGN)
            begin
                phase_reg <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                last_x_reg <= ex_reg;
                last_y_reg <= ey_reg;
                last_b_reg <= pb_reg;
                last_r_reg <= pr_reg;
                have_last_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_s_reg <= rs_reg;
            o_p_reg <= rp_reg;
            o_v_reg <= rv_reg;
            o_sh_reg <= rsh_reg;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sx_reg <= start_x;
                    sy_reg <= start_y;
                    ex_reg <= end_x;
                    ey_reg <= end_y;
                    first_reg <= first_segment;
                end
            end
            P_MX, S_GX, S_THR:
            begin
                prod_reg <= 50'(mul_p);
            end
            P_MY, S_GY:
            begin
                acc_reg <= prod_reg;
                prod_reg <= 50'(mul_p);
            end
            S_GSUM:
            begin
                acc_reg <= acc_reg + prod_reg;
            end
            P_WAIT:
            begin
                pr_reg <= sq_root;
                pb_reg <= (px == 0 && py == 0) ? 16'sd0 : bear_r[15:0];
            end
            S_DECIDE:
            begin
                d_reg <= pr_reg;
            end
            S_ROT:
            begin
                sine_reg <= sin_c;
            end
            S_CMP:
            begin
                shared_reg <= acc_reg <= thr;
                exact_reg <= acc_reg == '0;
                prev_near_reg <= last_r_reg <= pr_reg;
                d_reg <= (pr_reg < last_r_reg) ? pr_reg : last_r_reg;
            end
            S_DIV:
            begin
                score_reg <= 16'hFFFF;
            end
            S_DIVW:
            begin
                score_reg <= (dv_quo > NumW'(49151)) ? 16'hFFFF : 16'(dv_quo) + 16'd16384;
            end
            S_ASSIGN:
            begin
                if (!linked)
                begin
                    rs_reg <= score_reg;
                    rp_reg <= have_last_reg ? 16'd16384 : 16'd0;
                    rv_reg <= have_last_reg;
                    rsh_reg <= 1'b0;
                end
                else if (shared_reg)
                begin
                    rs_reg <= exact_reg ? 16'd32768 : score_reg;
                    rp_reg <= exact_reg ? 16'd32768 : score_reg;
                    rv_reg <= 1'b1;
                    rsh_reg <= 1'b1;
                end
                else
                begin
                    rs_reg <= prev_near_reg ? fake_reg : score_reg;
                    rp_reg <= prev_near_reg ? score_reg : fake_reg;
                    rv_reg <= 1'b1;
                    rsh_reg <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign start_score = o_s_reg;
    assign prev_end_score = o_p_reg;
    assign prev_end_valid = o_v_reg;
    assign shared_vertex = o_sh_reg;

endmodule

/* hw/rtl/lel_check.sv */
module lel_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] start_score,
    input logic [15:0] prev_end_score,
    input logic        prev_end_valid,
    input logic        shared_vertex
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(start_score)
            && $stable(prev_end_score))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready during segment work");

    a_shared_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && shared_vertex |-> prev_end_valid && start_score == prev_end_score)
        else $error("shared vertex scores differ");

    a_no_prev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !prev_end_valid |-> prev_end_score == 16'd0 && !shared_vertex)
        else $error("previous end fields set without previous end");

endmodule

bind line_endpoint_likelihood lel_check u_lel_check (.*);

/* dv/line_endpoint_likelihood_test.sv */
`timescale 1ns / 100ps

module line_endpoint_likelihood_test;
    import lel_pkg::*;

    localparam int STEPS = 16;
    localparam int SETTLE_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint HALF_PI = 26353589;
    localparam longint FULL_PI = 52707179;
    localparam longint ROT_GAIN = 652032874;

    typedef struct {
        logic signed [CoordW-1:0] sx;
        logic signed [CoordW-1:0] sy;
        logic signed [CoordW-1:0] ex;
        logic signed [CoordW-1:0] ey;
        logic                     first;
    } segment_t;

    typedef struct {
        logic [ScoreW-1:0] start_score;
        logic [ScoreW-1:0] prev_end_score;
        logic              prev_end_valid;
        logic              shared_vertex;
    } scores_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic first_segment;
    logic out_valid;
    logic out_ready;
    logic [ScoreW-1:0] start_score;
    logic [ScoreW-1:0] prev_end_score;
    logic prev_end_valid;
    logic shared_vertex;
    logic cfg_we;
    logic cfg_addr;
    logic [16:0] cfg_data;

    line_endpoint_likelihood #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .first_segment(first_segment),
        .out_valid(out_valid), .out_ready(out_ready),
        .start_score(start_score), .prev_end_score(prev_end_score),
        .prev_end_valid(prev_end_valid), .shared_vertex(shared_vertex),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    longint arctan_tbl[24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    // predictor state
    longint dmin;
    longint fake_score;
    longint tail_x;
    longint tail_y;
    longint tail_bearing;
    longint tail_range;
    bit     tail_seen;

    scores_t pending_scores[$];
    int mismatches;
    int beats_in;
    int beats_out;
    int n_shared;
    int n_gap;
    int n_frame;
    int idle_cycles;
    int burst_left;

    function automatic longint isqrt(longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = longint'(1) << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint point_range(longint px, longint py);
        return isqrt(px * px + py * py);
    endfunction

    function automatic longint point_bearing(longint px, longint py);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        if (px == 0 && py == 0) return 0;
        x = px * 65536;
        y = py * 65536;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HALF_PI;
            end else begin
                x = -y; y = t; z = -HALF_PI;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += arctan_tbl[i];
            end else begin
                x -= dx; y += dy; z -= arctan_tbl[i];
            end
        end
        return (z + 1024) >>> 11;
    endfunction

    function automatic longint half_angle_sine(longint db);
        longint h;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint s;
        h = (db < 0 ? -db : db) * 1024;
        x = ROT_GAIN;
        y = 0;
        if (h > HALF_PI) h = FULL_PI - h;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (h >= 0) begin
                x -= dx; y += dy; h -= arctan_tbl[i];
            end else begin
                x += dx; y -= dy; h += arctan_tbl[i];
            end
        end
        s = y >>> 14;
        if (s < 0) s = 0;
        if (s > 65536) s = 65536;
        return s;
    endfunction

    function automatic longint range_score(longint d);
        longint den;
        longint q;
        den = 65536 + d - dmin;
        if (den <= 0) return 65535;
        q = ((longint'(1) << 30) + den / 2) / den;
        if (q > 65535 - 16384) return 65535;
        return 16384 + q;
    endfunction

    function automatic scores_t predict_scores(segment_t seg);
        scores_t r;
        longint sx;
        longint sy;
        longint r1;
        longint b1;
        longint dx;
        longint dy;
        longint gap2;
        longint thr;
        longint d;
        longint pv;
        longint ss;
        longint ps;
        sx = longint'(seg.sx);
        sy = longint'(seg.sy);
        r1 = point_range(sx, sy);
        b1 = point_bearing(sx, sy);
        ps = 0;
        r.prev_end_valid = 0;
        r.shared_vertex = 0;
        if (seg.first || !tail_seen) begin
            ss = range_score(r1);
            if (tail_seen) begin
                r.prev_end_valid = 1;
                ps = 16384;
            end
            n_frame++;
        end else begin
            dx = sx - tail_x;
            dy = sy - tail_y;
            gap2 = dx * dx + dy * dy;
            thr = 4 * r1 * half_angle_sine(b1 - tail_bearing);
            d = r1 < tail_range ? r1 : tail_range;
            pv = range_score(d);
            r.prev_end_valid = 1;
            if (gap2 <= thr) begin
                r.shared_vertex = 1;
                ss = (gap2 == 0) ? 32768 : pv;
                ps = ss;
                n_shared++;
            end else if (tail_range <= r1) begin
                ps = pv;
                ss = fake_score;
                n_gap++;
            end else begin
                ps = fake_score;
                ss = pv;
                n_gap++;
            end
        end
        tail_x = longint'(seg.ex);
        tail_y = longint'(seg.ey);
        tail_bearing = point_bearing(tail_x, tail_y);
        tail_range = point_range(tail_x, tail_y) & 64'hFFFFFF;
        tail_seen = 1;
        r.start_score = ss[15:0];
        r.prev_end_score = ps[15:0];
        return r;
    endfunction

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver stall pattern: free, light, heavy or bursty stalls
    logic [1:0] stall_mode;
    int stall_count;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_mode <= 2'd0;
            stall_count <= 0;
        end
        else
        begin
            stall_count <= stall_count + 1;
            if (stall_count % 300 == 299) stall_mode <= 2'($urandom_range(0, 3));
            case (stall_mode)
                2'd0: out_ready <= 1'b1;
                2'd1: out_ready <= ($urandom_range(0, 3) != 0);
                2'd2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((stall_count / 16) % 2 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        scores_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_out++;
            if (pending_scores.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: start %0d prev %0d", start_score,
                             prev_end_score);
            end
            else
            begin
                want = pending_scores.pop_front();
                if (start_score !== want.start_score || prev_end_score !== want.prev_end_score
                    || prev_end_valid !== want.prev_end_valid
                    || shared_vertex !== want.shared_vertex)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 beats_out, want.start_score, want.prev_end_score,
                                 want.prev_end_valid, want.shared_vertex, start_score,
                                 prev_end_score, prev_end_valid, shared_vertex);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_segment(segment_t seg);
        scores_t want;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        start_x <= seg.sx;
        start_y <= seg.sy;
        end_x <= seg.ex;
        end_y <= seg.ey;
        first_segment <= seg.first;
        do @(posedge clk); while (!(in_valid && in_ready));
        want = predict_scores(seg);
        pending_scores = {pending_scores, want};
        beats_in++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic addr, logic [16:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_NEAR_RANGE_OFFSET)
            dmin = longint'(value);
        else
            fake_score = longint'(value[15:0]);
        @(posedge clk);
    endtask

    function automatic logic signed [CoordW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return CoordW'($urandom);
            1: return CoordW'(int'($urandom_range(0, 511)) - 256);
            default: return CoordW'(int'($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    function automatic segment_t make_segment(longint sx, longint sy, longint ex, longint ey,
                                              bit first);
        segment_t s;
        s.sx = sx[23:0];
        s.sy = sy[23:0];
        s.ex = ex[23:0];
        s.ey = ey[23:0];
        s.first = first;
        return s;
    endfunction

    // segment whose start lands on or near the previous end
    function automatic segment_t chained_segment(segment_t prev);
        segment_t s;
        int jitter;
        jitter = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 64);
        s.sx = prev.ex + CoordW'(int'($urandom_range(0, 2 * jitter)) - jitter);
        s.sy = prev.ey + CoordW'(int'($urandom_range(0, 2 * jitter)) - jitter);
        s.ex = s.sx + CoordW'(int'($urandom_range(0, 262144)) - 131072);
        s.ey = s.sy + CoordW'(int'($urandom_range(0, 262144)) - 131072);
        s.first = ($urandom_range(0, 19) == 0);
        return s;
    endfunction

    task automatic test_first_after_reset;
        send_segment(make_segment(65536, 0, 131072, 65536, 0));
        send_segment(make_segment(131072, 65536, 0, 0, 0));
        send_segment(make_segment(0, 0, -65536, 0, 0));
        send_segment(make_segment(100, 100, 200, -300, 1));
        drain();
    endtask

    task automatic test_extremes;
        longint mx;
        longint mn;
        mx = 8388607;
        mn = -8388608;
        send_segment(make_segment(mx, mx, mn, mn, 1));
        send_segment(make_segment(mn, mn, mx, mn, 0));
        send_segment(make_segment(mx, mn, mn, mx, 0));
        send_segment(make_segment(mn, mx, 0, 0, 0));
        send_segment(make_segment(0, 0, 0, 0, 0));
        send_segment(make_segment(0, 0, mx, 0, 0));
        send_segment(make_segment(-mx, 0, 0, mn, 0));
        send_segment(make_segment(0, -65536, 65536, 0, 0));
        // joins where the start range equals the previous end range, and one where it does not
        send_segment(make_segment(-65536, 0, -1, -1, 0));
        send_segment(make_segment(65536, 65536, 3, 4, 0));
        send_segment(make_segment(-5, 0, 7, 7, 0));
        drain();
    endtask

    task automatic test_vertex_chain;
        segment_t s;
        s = make_segment(327680, 0, 327680, 327680, 1);
        send_segment(s);
        for (int i = 0; i < 8; i++)
        begin
            s = chained_segment(s);
            send_segment(s);
        end
        drain();
    endtask

    task automatic test_register_sweep;
        logic [16:0] offs[5] = '{17'd0, 17'd65536, 17'd131071, 17'd6554, 17'd1};
        logic [16:0] fakes[5] = '{17'd0, 17'd65535, 17'd32768, 17'd8192, 17'd1};
        segment_t s;
        for (int k = 0; k < 5; k++)
        begin
            write_reg(REG_NEAR_RANGE_OFFSET, offs[k]);
            write_reg(REG_FAKE_EXTREME_SCORE, fakes[k]);
            s = make_segment(10, 10, 65536, 0, 1);
            send_segment(s);
            for (int i = 0; i < 30; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    s = make_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                     $urandom_range(0, 9) == 0);
                else
                    s = chained_segment(s);
                send_segment(s);
            end
            drain();
        end
    endtask

    task automatic test_random_scans;
        segment_t s;
        s = make_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1);
        for (int i = 0; i < 600; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                s = make_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                 $urandom_range(0, 9) == 0);
            else
                s = chained_segment(s);
            send_segment(s);
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        first_segment = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_NEAR_RANGE_OFFSET;
        cfg_data = '0;
        dmin = 6554;
        fake_score = 8192;
        tail_x = 0;
        tail_y = 0;
        tail_bearing = 0;
        tail_range = 0;
        tail_seen = 0;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        n_shared = 0;
        n_gap = 0;
        n_frame = 0;
        idle_cycles = 0;
        burst_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_after_reset();
        test_extremes();
        test_vertex_chain();
        test_register_sweep();
        write_reg(REG_NEAR_RANGE_OFFSET, 17'd6554);
        write_reg(REG_FAKE_EXTREME_SCORE, 17'd8192);
        test_random_scans();

        $display("segments %0d, results %0d: %0d shared vertices, %0d gaps, %0d frame starts",
                 beats_in, beats_out, n_shared, n_gap, n_frame);
        $display("register sweep covered offset 0..131071 and fake score 0..65535");
        if (mismatches == 0 && pending_scores.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
